>>> hdl/spq_pkg.sv
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_ABSENT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic execute;
	} dp_cmd_t;

	// datapath to top
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

>>> hdl/sorted_priority_queue.sv
// channel   direction  handshake             payload
// request   in         in_valid / in_ready   req_type[1:0], value[31:0] signed
// result    out        out_valid / out_ready hit, status[1:0], position[3:0],
//                                            count[4:0], head_value[31:0], head_valid
//
// a request runs in a compare step, which checks the value against every cell
// of the sorted chain at once, then a shift step, which shifts the chain and
// registers the result; a new request is taken in the cycle its predecessor's
// result is registered, so no new request is taken during a compare step
// arst_n clears the entry count and the control state; cell contents stay unset
// a result held back by out_ready stalls the shift step, the compare step still runs
module sorted_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic [1:0]          status,
	output logic [3:0]          position,
	output logic [4:0]          count,
	output logic signed [31:0]  head_value,
	output logic                head_valid
);

	// commands from the sequencer and status from the cell chain
	spq_pkg::dp_cmd_t  cmd;
	spq_pkg::dp_stat_t dp_stat;

	// sequencer: idle, compare, execute
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// sorted cell chain with the result register
	spq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.value      (value),
		.hit        (hit),
		.status     (status),
		.position   (position),
		.count      (count),
		.head_value (head_value),
		.head_valid (head_valid),
		.stat       (dp_stat)
	);

	// a request accepted now is being compared next cycle, so no second one is taken
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one still in compare");

	// a successful result always carries ok status
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == spq_pkg::STAT_OK)
		else $error("hit reported with non-ok status");

	// a full rejection is only reported while the chain really is full
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::STAT_FULL |-> dp_stat.full && !hit)
		else $error("full status while chain not full");

	// head flag follows the reported count, and the count the chain state
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> head_valid == (count != 5'd0) && head_valid == !dp_stat.empty)
		else $error("head_valid disagrees with count");

endmodule

>>> hdl/spq_ctrl.sv
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output spq_pkg::dp_cmd_t  cmd
);

	spq_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.execute)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.compare = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = spq_pkg::ST_CMP;
				end
			end
			spq_pkg::ST_CMP: begin
				cmd.compare = 1'b1;
				state_nxt   = spq_pkg::ST_EXEC;
			end
			spq_pkg::ST_EXEC: begin
				if (out_free) begin
					cmd.execute = 1'b1;
					in_ready    = 1'b1;
					if (in_valid) begin
						cmd.load  = 1'b1;
						state_nxt = spq_pkg::ST_CMP;
					end else begin
						state_nxt = spq_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = spq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/spq_dp.sv
module spq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::dp_cmd_t    cmd,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  value,
	output logic                hit,
	output logic [1:0]          status,
	output logic [3:0]          position,
	output logic [4:0]          count,
	output logic signed [31:0]  head_value,
	output logic                head_valid,
	output spq_pkg::dp_stat_t   stat
);

	localparam int D = spq_pkg::QUEUE_DEPTH;

	logic [1:0]                  req_q;
	logic signed [31:0]          value_q;
	logic signed [31:0]          cells_q [D];
	logic [spq_pkg::CNT_W-1:0]   count_q;
	logic [D-1:0]                ge_q;
	logic [D-1:0]                eq_q;

	logic signed [31:0]          cells_nxt [D];
	logic [spq_pkg::CNT_W-1:0]   count_nxt;
	logic [D-1:0]                at_or_after;
	logic [D-1:0]                first_eq;
	logic [D-1:0]                ins_here;
	logic [spq_pkg::IDX_W-1:0]   eq_idx;
	logic                        found;
	logic                        full;
	logic                        hit_nxt;
	logic [1:0]                  status_nxt;
	logic [spq_pkg::IDX_W-1:0]   pos_nxt;

	assign full       = (count_q == spq_pkg::CNT_W'(D));
	assign found      = |eq_q;
	assign stat.full  = full;
	assign stat.empty = (count_q == '0);

	// request capture and per-cell compare
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			value_q <= value;
		end
		if (cmd.compare) begin
			for (int i = 0; i < D; i++) begin
				ge_q[i] <= (spq_pkg::CNT_W'(i) < count_q) && (cells_q[i] >= value_q);
				eq_q[i] <= (spq_pkg::CNT_W'(i) < count_q) && (cells_q[i] == value_q);
			end
		end
	end

	// masks: cells at or after the first match, the first match and its index, and the insertion slot
	always_comb begin
		eq_idx = '0;
		for (int i = 0; i < D; i++) begin
			at_or_after[i] = |(eq_q & ({D{1'b1}} >> (D - 1 - i)));
		end
		for (int i = 0; i < D; i++) begin
			if (i == 0) begin
				first_eq[i] = eq_q[i];
				ins_here[i] = !ge_q[i];
			end else begin
				first_eq[i] = eq_q[i] && !at_or_after[i-1];
				ins_here[i] = !ge_q[i] && ge_q[i-1];
			end
			eq_idx = eq_idx | (spq_pkg::IDX_W'(i) & {spq_pkg::IDX_W{first_eq[i]}});
		end
	end

	always_comb begin
		cells_nxt  = cells_q;
		count_nxt  = count_q;
		hit_nxt    = 1'b0;
		status_nxt = spq_pkg::STAT_OK;
		pos_nxt    = '0;
		case (req_q)
			spq_pkg::REQ_INSERT: begin
				if (full) begin
					status_nxt = spq_pkg::STAT_FULL;
				end else begin
					hit_nxt   = 1'b1;
					count_nxt = count_q + 1'b1;
					for (int i = 0; i < D; i++) begin
						if (ins_here[i])
							cells_nxt[i] = value_q;
						else if (i > 0 && !ge_q[i])
							cells_nxt[i] = cells_q[i-1];
					end
				end
			end
			spq_pkg::REQ_REMOVE, spq_pkg::REQ_FIND: begin
				if (!found) begin
					status_nxt = spq_pkg::STAT_ABSENT;
				end else begin
					hit_nxt = 1'b1;
					pos_nxt = eq_idx;
					if (req_q == spq_pkg::REQ_REMOVE) begin
						count_nxt = count_q - 1'b1;
						for (int i = 0; i < D - 1; i++) begin
							if (at_or_after[i])
								cells_nxt[i] = cells_q[i+1];
						end
					end
				end
			end
			default: begin
				// unused request code leaves the chain and count as they are, with no hit and ok status
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			cells_q    <= cells_nxt;
			hit        <= hit_nxt;
			status     <= status_nxt;
			position   <= 4'(pos_nxt);
			count      <= 5'(count_nxt);
			head_value <= (count_nxt != '0) ? cells_nxt[0] : 32'sd0;
			head_valid <= (count_nxt != '0);
		end
	end

endmodule
